[rtl/llf_pkg.sv]
// Package: constants and types for the ladder lowpass filter.
package llf_pkg;

    localparam int SampleWidth   = 16;
    localparam int InternalWidth = 24;

    localparam logic [15:0] KDc   = 16'd65208;
    localparam logic [15:0] KA    = 16'd15124;
    localparam logic [15:0] KB    = 16'd50412;
    localparam logic [15:0] P1    = 16'd64829;
    localparam logic [15:0] P2    = 16'd28456;
    localparam logic [15:0] P3    = 16'd9051;
    localparam logic [15:0] P4    = 16'd1324;
    localparam logic [15:0] GMax  = 16'd58982;
    localparam logic [15:0] FcMax = 16'd27525;
    localparam logic [15:0] ResMax = 16'd62259;
    localparam logic [15:0] CutoffReset = 16'd1486;
    localparam logic [15:0] ResReset    = 16'd6554;

    localparam logic CfgCutoff = 1'b0;
    localparam logic CfgRes    = 1'b1;

    // datapath operations, one per step
    typedef enum logic [3:0] {
        OP_NONE, OP_G1, OP_G2, OP_G3, OP_G4,
        OP_DC, OP_FB, OP_TGT, OP_POLE, OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       load;   // latch input sample
        logic [1:0] stage;
    } t_cmd;

endpackage

[rtl/llf_ctrl.sv]
// Controller: sequences gain recompute and per-sample steps.
module llf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_gain_req,
    input  logic           i_out_free,
    output llf_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import llf_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_GAIN, S_DC, S_FB, S_TGT, S_POLE, S_OUT} t_state;

    t_state     r_state;
    logic [1:0] r_cnt;
    logic       r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_GAIN;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            // a pending recompute is consumed when the idle state starts it
            if (r_state == S_IDLE && (r_pend || i_gain_req)) r_pend <= 1'b0;
            else if (i_gain_req) r_pend <= 1'b1;
            unique case (r_state)
                S_IDLE: begin
                    if (r_pend || i_gain_req) begin
                        r_state <= S_GAIN; r_cnt <= '0;
                    end else if (i_start) begin
                        r_state <= S_DC;
                    end
                end
                S_GAIN: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) r_state <= S_IDLE;
                end
                S_DC: begin r_state <= S_FB; r_cnt <= '0; end
                S_FB: r_state <= S_TGT;
                S_TGT: r_state <= S_POLE;
                S_POLE: begin
                    r_cnt <= r_cnt + 2'd1;
                    r_state <= (r_cnt == 2'd3) ? S_OUT : S_TGT;
                end
                S_OUT: if (i_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd = '{op: OP_NONE, load: 1'b0, stage: r_cnt};
        unique case (r_state)
            S_IDLE: o_cmd.load = i_start && !(r_pend || i_gain_req);
            S_GAIN: begin
                unique case (r_cnt)
                    2'd0: o_cmd.op = OP_G1;
                    2'd1: o_cmd.op = OP_G2;
                    2'd2: o_cmd.op = OP_G3;
                    default: o_cmd.op = OP_G4;
                endcase
            end
            S_DC:   o_cmd.op = OP_DC;
            S_FB:   o_cmd.op = OP_FB;
            S_TGT:  o_cmd.op = OP_TGT;
            S_POLE: o_cmd.op = OP_POLE;
            S_OUT:  o_cmd.op = i_out_free ? OP_OUT : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE) || r_pend || i_gain_req;
endmodule

[rtl/llf_dp.sv]
// Datapath: one shared multiplier, filter state and gain polynomial.
module llf_dp #(
    parameter int SAMPLE_WIDTH   = llf_pkg::SampleWidth,
    parameter int INTERNAL_WIDTH = llf_pkg::InternalWidth
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  llf_pkg::t_cmd                   i_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_sample,
    input  logic [15:0]                     i_cutoff,
    input  logic [15:0]                     i_res,
    output logic signed [SAMPLE_WIDTH-1:0]  o_sample
);
    import llf_pkg::*;

    localparam int IW   = INTERNAL_WIDTH;
    localparam int IF   = INTERNAL_WIDTH - 6;
    localparam int SF   = SAMPLE_WIDTH - 1;
    localparam int PW   = IW + 20;
    localparam logic signed [IW-1:0] IMax  = IW'((64'sd1 <<< (IW-1)) - 1);
    localparam logic signed [IW-1:0] IMin  = ~IMax;
    localparam logic signed [IW-1:0] FbLim = IW'((64'sd6 <<< IF) / 5);
    localparam logic signed [IW-1:0] StLim = IW'(64'sd5 <<< IF);
    localparam logic signed [IW-1:0] OneI  = IW'(64'sd1 <<< IF);
    localparam logic signed [PW-1:0] SMax  = PW'((64'sd1 <<< SF) - 1);

    logic signed [IW-1:0]    r_pole [4];
    logic signed [IW-1:0]    r_pin  [4];
    logic signed [SAMPLE_WIDTH-1:0] r_x, r_xprev;
    logic signed [IW-1:0]    r_dc, r_u, r_tgt;
    logic [15:0]             r_gain;
    logic signed [19:0]      r_t;   // Horner accumulator
    logic signed [SAMPLE_WIDTH-1:0] r_out;

    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
                                                input int s);
        logic signed [PW-1:0] h;
        if (s <= 0) return v;
        h = PW'(1) <<< (s - 1);
        return (v + h) >>> s;
    endfunction

    // move between fraction lengths, rounding when bits are dropped
    function automatic logic signed [PW-1:0] aln(input logic signed [PW-1:0] v,
                                                input int fs, input int ts);
        if (ts >= fs) return v <<< (ts - fs);
        return rnd(v, fs - ts);
    endfunction

    function automatic logic signed [IW-1:0] satw(input logic signed [PW-1:0] v,
                                                 input logic signed [IW-1:0] lim);
        logic signed [IW-1:0] r;
        if (v > PW'(lim)) r = lim;
        else if (v < -PW'(lim)) r = -lim;
        else r = v[IW-1:0];
        return r;
    endfunction

    function automatic logic signed [IW-1:0] sati(input logic signed [PW-1:0] v);
        logic signed [IW-1:0] r;
        if (v > PW'(IMax)) r = IMax;
        else if (v < PW'(IMin)) r = IMin;
        else r = v[IW-1:0];
        return r;
    endfunction

    logic [15:0]             fc, res;
    logic signed [IW:0]      ma;
    logic signed [16:0]      mb;
    logic signed [IW+17:0]   prod_n, ka_p, kb_p;
    logic signed [PW-1:0]    prod, a_x, a_xp, g_tmp, o_tmp;
    logic signed [IW-1:0]    y1, cur;

    assign fc  = (i_cutoff > FcMax) ? FcMax : i_cutoff;
    assign res = (i_res > ResMax) ? ResMax : i_res;
    assign cur = r_pole[i_cmd.stage];

    // shared multiplier operand select
    always_comb begin
        ma = '0; mb = '0;
        unique case (i_cmd.op)
            OP_G1:   begin ma = (IW+1)'(P4);  mb = $signed({1'b0, fc}); end
            OP_G2, OP_G3, OP_G4: begin ma = (IW+1)'(r_t); mb = $signed({1'b0, fc}); end
            OP_DC:   begin ma = (IW+1)'(r_dc); mb = $signed({1'b0, KDc}); end
            OP_FB:   begin ma = (IW+1)'(r_pole[3]); mb = $signed({1'b0, res}); end
            OP_POLE: begin
                ma = (IW+1)'(r_tgt) - (IW+1)'(cur);
                mb = $signed({1'b0, r_gain});
            end
            default: ;
        endcase
        prod_n = ma * mb;
        prod   = PW'(prod_n);
    end

    // stage target coefficients
    assign ka_p = $signed({1'b0, KA}) * r_u;
    assign kb_p = $signed({1'b0, KB}) * r_pin[i_cmd.stage];

    assign a_x  = aln(PW'(r_x), SF, IF);
    assign a_xp = aln(PW'(r_xprev), SF, IF);
    assign y1   = (r_pole[3] > OneI) ? OneI : ((r_pole[3] < -OneI) ? -OneI : r_pole[3]);
    assign g_tmp = rnd(prod, 16);
    assign o_tmp = aln(PW'(y1), IF, SF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin r_pole[i] <= '0; r_pin[i] <= '0; end
            r_xprev <= '0;
            r_dc    <= '0;
        end else begin
            if (i_cmd.load) r_x <= i_sample;
            unique case (i_cmd.op)
                OP_G1: r_t <= 20'(PW'(P3) - rnd(prod, 16));
                OP_G2: r_t <= 20'(-PW'(P2) + rnd(prod, 16));
                OP_G3: r_t <= 20'(PW'(P1) + rnd(prod, 16));
                OP_G4: begin
                    r_gain <= (g_tmp < 0) ? 16'd0 :
                              ((g_tmp > PW'(GMax)) ? GMax : g_tmp[15:0]);
                end
                OP_DC: begin
                    r_dc    <= sati(a_x - a_xp + rnd(prod, 16));
                    r_xprev <= r_x;
                end
                OP_FB: r_u <= sati(PW'(r_dc) - PW'(satw(rnd(prod, 14), FbLim)));
                OP_TGT: r_tgt <= IW'(rnd(PW'(ka_p) + PW'(kb_p), 16));
                OP_POLE: begin
                    r_pole[i_cmd.stage] <= satw(PW'(cur) + rnd(prod, 16), StLim);
                    r_pin[i_cmd.stage]  <= r_u;
                    r_u <= satw(PW'(cur) + rnd(prod, 16), StLim);
                end
                OP_OUT: begin
                    if (o_tmp > SMax) r_out <= SAMPLE_WIDTH'(SMax);
                    else r_out <= o_tmp[SAMPLE_WIDTH-1:0];
                end
                default: ;
            endcase
        end
    end

    assign o_sample = r_out;
endmodule

[rtl/ladder_lowpass_filter_unit.sv]
// A new sample is not accepted while one is in process; the next is taken once the result
// leaves the output step. A cutoff write inserts a gain recompute (steps G1 to G4).
// One shared multiplier serves gain, DC, feedback and pole steps; the target uses two more.
// Output register frees the input side once the result is taken or latched.
// Reset (synchronous, active low) clears filter state, loads reset registers
// and recomputes the stage gain (steps G1 to G4) before accepting input.
module ladder_lowpass_filter_unit #(
    parameter int SAMPLE_WIDTH   = llf_pkg::SampleWidth,
    parameter int INTERNAL_WIDTH = llf_pkg::InternalWidth
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [SAMPLE_WIDTH-1:0] s_axis_tdata,   // [sample_in]
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [SAMPLE_WIDTH-1:0] m_axis_tdata,   // [sample_out]
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_index,
    input  logic [15:0]             i_cfg_data
);
    import llf_pkg::*;

    logic [15:0] r_cutoff, r_res;
    logic        r_valid, busy, gain_req, start;
    t_cmd        cmd;
    logic signed [SAMPLE_WIDTH-1:0] dp_out;

    assign gain_req = i_cfg_we && (i_cfg_index == CfgCutoff);
    assign s_axis_tready = !busy;
    assign start = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= CutoffReset;
            r_res    <= ResReset;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == CfgCutoff) r_cutoff <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == CfgRes)    r_res    <= i_cfg_data;
            if (cmd.op == OP_OUT) r_valid <= 1'b1;
            else if (m_axis_tready) r_valid <= 1'b0;
        end
    end

    llf_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_gain_req(gain_req),
        .i_out_free(!r_valid || m_axis_tready), .o_cmd(cmd), .o_busy(busy)
    );

    llf_dp #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .INTERNAL_WIDTH(INTERNAL_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_sample(s_axis_tdata),
        .i_cutoff(r_cutoff), .i_res(r_res), .o_sample(dp_out)
    );

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = dp_out;

`ifndef SYNTHESIS
    a_out_after_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_OUT) |=> m_axis_tvalid) else $error("result not presented");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op != OP_NONE) |-> !s_axis_tready) else $error("accept during work");
`endif
endmodule
